/* rtl/core/keyed_time_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// keyed_time_priority_queue_defines
// assertion macros used by the queue top level
// ----------------------------------------------------------------------------
`ifndef KEYED_TIME_PRIORITY_QUEUE_DEFINES_SVH
`define KEYED_TIME_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define KTPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ktpq_pkg.sv */
// ----------------------------------------------------------------------------
// ktpq_pkg
// types and constants of the keyed time priority queue
// ----------------------------------------------------------------------------
package ktpq_pkg;

    localparam int KEY_BITS     = 24;
    localparam int TIME_BITS    = 48;
    localparam int REF_BITS     = 16;
    localparam int COUNT_BITS   = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } ktpq_mode_t;

    typedef struct packed
    {
        ktpq_mode_t            mode;
        logic [KEY_BITS-1:0]   voxel_key;
        logic [TIME_BITS-1:0]  event_time;
        logic                  payload_kind;
        logic [REF_BITS-1:0]   payload_ref;
    } ktpq_in_t;

    typedef struct packed
    {
        logic                  head_valid;
        logic [KEY_BITS-1:0]   head_key;
        logic [TIME_BITS-1:0]  head_time;
        logic                  head_kind;
        logic [REF_BITS-1:0]   head_ref;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  key_found;
        logic                  insert_dropped;
    } ktpq_out_t;

    typedef struct packed
    {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [TIME_BITS-1:0]  time_val;
        logic                  kind;
        logic [REF_BITS-1:0]   ref_val;
    } ktpq_entry_t;

    typedef struct packed
    {
        logic compare_en;
        logic apply_en;
        logic shift;
        logic insert_en;
        logic first;
    } ktpq_cell_ctrl_t;

endpackage

/* rtl/core/ktpq_cell.sv */
// ----------------------------------------------------------------------------
// ktpq_cell
// one slot of the sorted event row: key match, removal shift, ordered insert
// ----------------------------------------------------------------------------
module ktpq_cell
    import ktpq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  ktpq_cell_ctrl_t ctrl,
    input  ktpq_entry_t     new_entry,
    input  ktpq_entry_t     up_entry,
    input  logic            up_le,
    input  ktpq_entry_t     dn_post_entry,
    input  logic            dn_post_le,
    output ktpq_entry_t     raw_entry,
    output logic            raw_le,
    output logic            raw_match,
    output ktpq_entry_t     post_entry,
    output logic            post_le,
    output ktpq_entry_t     next_entry
);

    logic                 valid_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 kind_reg;
    logic [REF_BITS-1:0]  ref_reg;
    logic                 le_reg;
    logic                 match_reg;

    assign raw_entry = '{valid: valid_reg, key: key_reg, time_val: time_reg,
                         kind: kind_reg, ref_val: ref_reg};
    assign raw_le    = le_reg;
    assign raw_match = match_reg;

    // contents after the removal step
    assign post_entry = ctrl.shift ? up_entry : raw_entry;
    assign post_le    = ctrl.shift ? up_le    : le_reg;

    // ordered insert on the compacted row
    always_comb
    begin
        if (!ctrl.insert_en || post_le)
        begin
            next_entry = post_entry;
        end
        else if (ctrl.first || dn_post_le)
        begin
            next_entry = new_entry;
        end
        else
        begin
            next_entry = dn_post_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.compare_en)
            begin
                le_reg    <= valid_reg && (time_reg <= new_entry.time_val);
                match_reg <= valid_reg && (key_reg == new_entry.key);
            end
            if (ctrl.apply_en)
            begin
                valid_reg <= next_entry.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply_en)
        begin
            key_reg  <= next_entry.key;
            time_reg <= next_entry.time_val;
            kind_reg <= next_entry.kind;
            ref_reg  <= next_entry.ref_val;
        end
    end

endmodule

/* rtl/core/ktpq_encode.sv */
// ----------------------------------------------------------------------------
// ktpq_encode
// turns the one-hot key match of the row into a found flag and slot index
// ----------------------------------------------------------------------------
module ktpq_encode
    import ktpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
)
(
    input  logic [CAPACITY-1:0] match,
    output logic                found,
    output logic [IDX_W-1:0]    index
);

    always_comb
    begin
        index = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

    assign found = |match;

endmodule

/* rtl/core/keyed_time_priority_queue.sv */
// ----------------------------------------------------------------------------
// keyed_time_priority_queue
// time-ordered event store with one event per key, built as a row of cells
// ----------------------------------------------------------------------------
// flow: an accepted item passes the match state, then the apply state; the
//   result strobe is registered from the apply step; key and time compare in
//   every cell, then removal shift and ordered insert; no new item until idle
// reset: valid bits and count clear at once, store empty, no clearing pass
// result is shown for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "keyed_time_priority_queue_defines.svh"

module keyed_time_priority_queue
    import ktpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ktpq_in_t  item,
    output logic      done,
    output ktpq_out_t result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    ktpq_in_t         item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    ktpq_out_t        result_reg;

    ktpq_entry_t          new_entry;
    ktpq_entry_t          raw_e  [CAPACITY];
    ktpq_entry_t          post_e [CAPACITY];
    ktpq_entry_t          next_e [CAPACITY];
    logic [CAPACITY-1:0]  raw_le, post_le, match;
    ktpq_cell_ctrl_t      cell_ctrl [CAPACITY];

    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [CNT_W-1:0] count_removed;
    logic             full;
    logic             is_insert;
    logic             insert_en;
    logic             accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign new_entry = '{valid: 1'b1, key: item_reg.voxel_key, time_val: item_reg.event_time,
                         kind: item_reg.payload_kind, ref_val: item_reg.payload_ref};

    ktpq_encode #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_encode (
        .match (match),
        .found (found),
        .index (found_idx)
    );

    assign count_removed = count_reg - CNT_W'(found);
    assign full          = (count_removed == CNT_W'(CAPACITY));
    assign is_insert     = (item_reg.mode == MODE_INSERT);
    assign insert_en     = is_insert && !full;
    assign count_next    = count_removed + CNT_W'(insert_en);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ktpq_entry_t up_entry, dn_entry;
        logic        up_le, dn_le;

        if (i == CAPACITY - 1)
        begin : g_last
            assign up_entry = '0;
            assign up_le    = 1'b0;
        end
        else
        begin : g_mid
            assign up_entry = raw_e[i+1];
            assign up_le    = raw_le[i+1];
        end

        if (i == 0)
        begin : g_first
            assign dn_entry = '0;
            assign dn_le    = 1'b0;
        end
        else
        begin : g_rest
            assign dn_entry = post_e[i-1];
            assign dn_le    = post_le[i-1];
        end

        assign cell_ctrl[i] = '{compare_en: (state_reg == ST_MATCH),
                                apply_en:   (state_reg == ST_APPLY),
                                shift:      found && (IDX_W'(i) >= found_idx),
                                insert_en:  insert_en,
                                first:      (i == 0)};

        ktpq_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (cell_ctrl[i]),
            .new_entry     (new_entry),
            .up_entry      (up_entry),
            .up_le         (up_le),
            .dn_post_entry (dn_entry),
            .dn_post_le    (dn_le),
            .raw_entry     (raw_e[i]),
            .raw_le        (raw_le[i]),
            .raw_match     (match[i]),
            .post_entry    (post_e[i]),
            .post_le       (post_le[i]),
            .next_entry    (next_e[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: state_next = ST_APPLY;
            ST_APPLY: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_APPLY);
            if (state_reg == ST_APPLY)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_APPLY)
        begin
            result_reg.head_valid     <= next_e[0].valid;
            result_reg.head_key       <= next_e[0].valid ? next_e[0].key      : '0;
            result_reg.head_time      <= next_e[0].valid ? next_e[0].time_val : '0;
            result_reg.head_kind      <= next_e[0].valid && next_e[0].kind;
            result_reg.head_ref       <= next_e[0].valid ? next_e[0].ref_val  : '0;
            result_reg.entry_count    <= COUNT_BITS'(count_next);
            result_reg.key_found      <= found;
            result_reg.insert_dropped <= is_insert && full;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `KTPQ_ASSERT_NEXT(a_accept_to_match, clk, rst_n, accept, state_reg == ST_MATCH, "accepted transfer did not start a match")
    `KTPQ_ASSERT_IMPL(a_done_after_apply, clk, rst_n, done_reg, $past(state_reg == ST_APPLY), "result strobe without apply step")
    `KTPQ_ASSERT_IMPL(a_head_vs_count, clk, rst_n, done_reg, result_reg.head_valid == (count_reg != '0), "head valid disagrees with count")
    `KTPQ_ASSERT_IMPL(a_drop_when_full, clk, rst_n, done_reg && result_reg.insert_dropped, (count_reg == CNT_W'(CAPACITY)) && !result_reg.key_found, "insert dropped while not full")

endmodule

/* bench/tb_keyed_time_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_keyed_time_priority_queue
// self-checking bench for the keyed time priority queue: a scoreboard keeps
// its own time-ordered copy of the event store, predicts the head report of
// every accepted transfer and compares each strobed result field by field;
// directed corner items come first, then random phases of inserts, replaces
// and removes over key pools of varied size, with random sender gaps
// ----------------------------------------------------------------------------
module tb_keyed_time_priority_queue
    import ktpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 95;
    localparam int DRAIN_CYCLES = 8;

    class event_queue_board;
        ktpq_entry_t slots [CAPACITY_DEF];
        int          held;
        ktpq_out_t   expected_reports [$];
        int          mismatches;

        function new();
            held = 0;
            mismatches = 0;
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        function ktpq_out_t apply_event(ktpq_in_t ev);
            ktpq_out_t rep;
            int        pos;
            rep = '0;
            for (int i = 0; i < held; i++)
            begin
                if (slots[i].key == ev.voxel_key)
                begin
                    for (int j = i; j + 1 < held; j++)
                        slots[j] = slots[j + 1];
                    held--;
                    slots[held] = '0;
                    rep.key_found = 1'b1;
                    break;
                end
            end
            if (ev.mode == MODE_INSERT)
            begin
                if (held >= CAPACITY_DEF)
                    rep.insert_dropped = 1'b1;
                else
                begin
                    pos = 0;
                    while (pos < held && slots[pos].time_val <= ev.event_time)
                        pos++;
                    for (int j = held; j > pos; j--)
                        slots[j] = slots[j - 1];
                    slots[pos].valid    = 1'b1;
                    slots[pos].key      = ev.voxel_key;
                    slots[pos].time_val = ev.event_time;
                    slots[pos].kind     = ev.payload_kind;
                    slots[pos].ref_val  = ev.payload_ref;
                    held++;
                end
            end
            if (held > 0)
            begin
                rep.head_valid = 1'b1;
                rep.head_key   = slots[0].key;
                rep.head_time  = slots[0].time_val;
                rep.head_kind  = slots[0].kind;
                rep.head_ref   = slots[0].ref_val;
            end
            rep.entry_count = COUNT_BITS'(held);
            return rep;
        endfunction

        function void note_transfer(ktpq_in_t ev);
            expected_reports.push_back(apply_event(ev));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(ktpq_out_t got);
            ktpq_out_t want;
            if (expected_reports.size() == 0)
            begin
                $error("result strobe with no transfer pending");
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("head_valid", want.head_valid, got.head_valid);
            compare_field("head_key", want.head_key, got.head_key);
            compare_field("head_time", want.head_time, got.head_time);
            compare_field("head_kind", want.head_kind, got.head_kind);
            compare_field("head_ref", want.head_ref, got.head_ref);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("key_found", want.key_found, got.key_found);
            compare_field("insert_dropped", want.insert_dropped, got.insert_dropped);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    ktpq_in_t  item;
    logic      done;
    ktpq_out_t result;

    event_queue_board board;
    int               cycles;
    bit               no_gap;
    logic [KEY_BITS-1:0] key_pool [256];

    keyed_time_priority_queue dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        board = new();
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_transfer(item);
        if (rst_n && done)
            board.check_report(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic ktpq_in_t make_event(ktpq_mode_t m, logic [KEY_BITS-1:0] k,
                                            logic [TIME_BITS-1:0] t, logic kd,
                                            logic [REF_BITS-1:0] r);
        ktpq_in_t ev;
        ev.mode         = m;
        ev.voxel_key    = k;
        ev.event_time   = t;
        ev.payload_kind = kd;
        ev.payload_ref  = r;
        return ev;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send(ktpq_in_t ev);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        item  = ev;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_all_reported();
        start = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [TIME_BITS-1:0] pick_time(bit narrow);
        logic [63:0] wide;
        if (narrow)
            return TIME_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default:
            begin
                wide = {$urandom, $urandom};
                return wide[TIME_BITS-1:0];
            end
        endcase
    endfunction

    task automatic run_phase(int pool_n, int insert_pct, bit sequential);
        bit                  narrow;
        int                  idx;
        logic [KEY_BITS-1:0] k;
        ktpq_mode_t          m;
        narrow = $urandom_range(0, 1);
        no_gap = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = KEY_BITS'($urandom);
        if ($urandom_range(0, 1))
        begin
            key_pool[0] = '0;
            key_pool[1] = '1;
        end
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            idx = sequential ? (n % pool_n) : $urandom_range(0, pool_n - 1);
            k   = key_pool[idx];
            m   = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            if (m == MODE_REMOVE && $urandom_range(0, 9) == 0)
                k = KEY_BITS'($urandom);
            send(make_event(m, k, pick_time(narrow), 1'($urandom),
                            REF_BITS'($urandom)));
        end
    endtask

    initial
    begin
        int pool_sizes [PHASES]  = '{4, 16, 80, 80, 48, 200, 8, 2, 80, 32, 120, 6};
        int insert_pcts [PHASES] = '{60, 50, 100, 85, 30, 70, 55, 50, 100, 65, 80, 20};
        bit seq_phase [PHASES]   = '{0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0};
        cycles = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        item   = '0;
        no_gap = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(make_event(MODE_REMOVE, 24'h000005, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_INSERT, 24'h000000, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_INSERT, 24'hffffff, 48'hffff_ffff_ffff, 1'b1, 16'hffff));
        send(make_event(MODE_INSERT, 24'h000001, 48'h0, 1'b1, 16'h0001));
        send(make_event(MODE_INSERT, 24'h000002, 48'd100, 1'b0, 16'h0002));
        send(make_event(MODE_INSERT, 24'h000000, 48'd200, 1'b1, 16'h1234));
        send(make_event(MODE_INSERT, 24'h000001, 48'hffff_ffff_ffff, 1'b0, 16'h4321));
        send(make_event(MODE_REMOVE, 24'h000002, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'h000002, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_INSERT, 24'h555555, 48'h5555_5555_5555, 1'b1, 16'h5555));
        send(make_event(MODE_INSERT, 24'haaaaaa, 48'haaaa_aaaa_aaaa, 1'b0, 16'haaaa));
        send(make_event(MODE_INSERT, 24'h123456, 48'hffff_ffff_fffe, 1'b1, 16'h00ff));
        send(make_event(MODE_REMOVE, 24'h000000, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'h000001, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'hffffff, 48'h0, 1'b1, 16'hffff));
        send(make_event(MODE_REMOVE, 24'h555555, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'haaaaaa, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'h123456, 48'h0, 1'b0, 16'h0000));
        send(make_event(MODE_REMOVE, 24'h123456, 48'h0, 1'b0, 16'h0000));
        wait_all_reported();

        for (int p = 0; p < PHASES; p++)
        begin
            run_phase(pool_sizes[p], insert_pcts[p], seq_phase[p]);
            wait_all_reported();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
